FILE: design/pcp_pkg.sv
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared constants, types and tables of the polygon centroid / polar block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcp_pkg;

   localparam int MAX_VERTICES = 32;
   localparam int CORDIC_STEPS = 16;
   localparam int SQRT_STEPS   = 18;
   localparam int POL_STEPS    = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
   localparam int POL_CNT_W    = $clog2(POL_STEPS);
   localparam int ADDR_W       = $clog2(MAX_VERTICES);
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
   localparam int NUM_W        = 60;
   localparam int DEN_W        = 43;
   localparam int DIV_CNT_W    = $clog2(NUM_W);
   localparam int CRD_W        = 32;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FEW  = 2'd1;
   localparam logic [1:0] ST_AREA = 2'd2;
   localparam logic [1:0] ST_OVF  = 2'd3;

   typedef enum logic [1:0] {
      DSEL_CX0,
      DSEL_CY0,
      DSEL_CX,
      DSEL_CY
   } div_sel_type;

   typedef enum logic [4:0] {
      S_LOAD,
      S_CHECK,
      S_WX0,
      S_DY0,
      S_WY0,
      S_ARDI,
      S_ARDJ,
      S_AMUL,
      S_ASUB,
      S_AWMUL,
      S_AACC,
      S_ACHK,
      S_DX,
      S_WX,
      S_DY,
      S_WY,
      S_PRD,
      S_PDIFF,
      S_PSQ,
      S_PSTART,
      S_PRUN,
      S_ERD,
      S_EOUT
   } state_type;

   typedef struct packed {
      logic              store_wr;
      logic              clear_poly;
      logic [ADDR_W-1:0] rd_addr;
      logic [ADDR_W-1:0] idx;
      logic              div_start;
      div_sel_type       div_sel;
      logic              div_take;
      logic              acc_clear;
      logic              cap_i;
      logic              area_mul;
      logic              area_sub;
      logic              area_wmul;
      logic              area_acc;
      logic              den_load;
      logic              pol_diff;
      logic              pol_sq;
      logic              pol_start;
      logic              pol_store;
      logic              out_load;
      logic [1:0]        out_status;
      logic              out_last;
   } cmd_type;

   typedef struct packed {
      logic             div_busy;
      logic             pol_busy;
      logic             out_free;
      logic             overflow;
      logic             area_bad;
      logic [CNT_W-1:0] count;
   } stat_type;

   function automatic logic [31:0] atan_val(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:    v = 32'h20000000;
         5'd1:    v = 32'h12E4051E;
         5'd2:    v = 32'h09FB385B;
         5'd3:    v = 32'h051111D4;
         5'd4:    v = 32'h028B0D43;
         5'd5:    v = 32'h0145D7E1;
         5'd6:    v = 32'h00A2F61E;
         5'd7:    v = 32'h00517C55;
         5'd8:    v = 32'h0028BE53;
         5'd9:    v = 32'h00145F2F;
         5'd10:   v = 32'h000A2F98;
         5'd11:   v = 32'h000517CC;
         5'd12:   v = 32'h00028BE6;
         5'd13:   v = 32'h000145F3;
         5'd14:   v = 32'h0000A2FA;
         5'd15:   v = 32'h0000517D;
         5'd16:   v = 32'h000028BE;
         5'd17:   v = 32'h0000145F;
         5'd18:   v = 32'h00000A30;
         5'd19:   v = 32'h00000518;
         5'd20:   v = 32'h0000028C;
         5'd21:   v = 32'h00000146;
         5'd22:   v = 32'h000000A3;
         5'd23:   v = 32'h00000051;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: design/pcp_if.sv
// ----------------------------------------------------------------------------
// pcp_req_if / pcp_rsp_if
// Valid/ready channels for vertex items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcp_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] vertex_x;
   logic signed [15:0] vertex_y;
   logic               last_vertex;

   modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                   input ready);
   modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                   output ready);
endinterface

interface pcp_rsp_if;
   logic               valid;
   logic               ready;
   logic [4:0]         vertex_index;
   logic [16:0]        polar_distance;
   logic signed [15:0] polar_angle;
   logic signed [15:0] centroid_x;
   logic signed [15:0] centroid_y;
   logic [16:0]        bound_radius;
   logic [1:0]         status;
   logic               last_result;

   modport source (output valid, output vertex_index, output polar_distance,
                   output polar_angle, output centroid_x, output centroid_y,
                   output bound_radius, output status, output last_result,
                   input ready);
   modport sink   (input valid, input vertex_index, input polar_distance,
                   input polar_angle, input centroid_x, input centroid_y,
                   input bound_radius, input status, input last_result,
                   output ready);
endinterface

`default_nettype wire

FILE: design/pcp_div.sv
// ----------------------------------------------------------------------------
// pcp_div
// Serial signed divider, one quotient bit per cycle, optional rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module pcp_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          rnd,
   input  wire logic signed [pcp_pkg::NUM_W-1:0] num,
   input  wire logic [pcp_pkg::DEN_W-1:0]     den,
   output logic                               busy,
   output logic signed [pcp_pkg::NUM_W:0]     quo
);
   import pcp_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 neg_ff, neg_in;
   logic [NUM_W-1:0]     q_ff, q_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]     mag;
   logic [DEN_W:0]       rem_sh;

   always_comb begin
      mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      mag    = mag + (rnd ? NUM_W'(den >> 1) : '0);
      rem_sh = {rem_ff, q_ff[NUM_W-1]};
      busy_in = busy_ff;
      neg_in  = neg_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = num[NUM_W-1];
         q_in    = mag;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(rem_sh - {1'b0, den_ff});
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      neg_ff <= neg_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign busy = busy_ff;
   assign quo  = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});

endmodule

`default_nettype wire

FILE: design/pcp_dp.sv
// ----------------------------------------------------------------------------
// pcp_dp
// Datapath: vertex store, fan sums, divider, square root, CORDIC, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module pcp_dp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pcp_pkg::cmd_type   cmd,
   output pcp_pkg::stat_type       stat,
   input  wire logic signed [15:0] in_x,
   input  wire logic signed [15:0] in_y,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output logic [4:0]              rsp_vertex_index,
   output logic [16:0]             rsp_polar_distance,
   output logic signed [15:0]      rsp_polar_angle,
   output logic signed [15:0]      rsp_centroid_x,
   output logic signed [15:0]      rsp_centroid_y,
   output logic [16:0]             rsp_bound_radius,
   output logic [1:0]              rsp_status,
   output logic                    rsp_last_result
);
   import pcp_pkg::*;

   logic [31:0] vert_mem_ff [MAX_VERTICES];
   logic [32:0] res_mem_ff  [MAX_VERTICES];
   logic [31:0] vrd_ff;
   logic [32:0] rrd_ff;

   logic [CNT_W-1:0]   count_ff;
   logic signed [20:0] sum_x_ff, sum_y_ff;
   logic               ovf_ff;

   logic signed [15:0] cx0_ff, cy0_ff, cx_ff, cy_ff;
   logic signed [15:0] xi_ff, yi_ff;
   logic signed [33:0] p1_ff, p2_ff;
   logic signed [17:0] wsx_ff, wsy_ff;
   logic signed [34:0] a2_ff;
   logic signed [52:0] pwx_ff, pwy_ff;
   logic signed [40:0] a2sum_ff;
   logic signed [58:0] wx_ff, wy_ff;
   logic [DEN_W-1:0]   den_ff;

   logic signed [16:0] dx_ff, dy_ff;
   logic [33:0]        dxx_ff, dyy_ff;
   logic [35:0]        sv_ff, sr_ff;
   logic signed [CRD_W-1:0] cxr_ff, cyr_ff;
   logic [31:0]        z_ff;
   logic               zero_ff;
   logic               pbusy_ff;
   logic [POL_CNT_W-1:0] pcnt_ff;
   logic [16:0]        rmax_ff;

   logic               rsp_valid_ff;
   logic [4:0]         o_idx_ff;
   logic [16:0]        o_dist_ff, o_rmax_ff;
   logic signed [15:0] o_ang_ff, o_cx_ff, o_cy_ff;
   logic [1:0]         o_st_ff;
   logic               o_last_ff;

   logic signed [15:0] rd_x, rd_y;
   logic signed [16:0] e1x, e1y, e2x, e2y;
   logic signed [NUM_W-1:0] dnum;
   logic [DEN_W-1:0]   dden;
   logic               drnd, dbusy;
   logic signed [NUM_W:0] dquo;
   logic signed [15:0] dsat;
   logic [35:0]        sbit, s_try;
   logic [35:0]        sroot;
   logic [16:0]        pol_dist;
   logic signed [CRD_W-1:0] xs, ys;
   logic [15:0]        ang;
   logic               out_free;

   assign rd_x = vrd_ff[31:16];
   assign rd_y = vrd_ff[15:0];
   assign e1x  = 17'(rd_x) - 17'(xi_ff);
   assign e1y  = 17'(rd_y) - 17'(yi_ff);
   assign e2x  = 17'(cx0_ff) - 17'(xi_ff);
   assign e2y  = 17'(cy0_ff) - 17'(yi_ff);

   always_comb begin
      case (cmd.div_sel)
         DSEL_CX0: begin
            dnum = NUM_W'(sum_x_ff);
            dden = DEN_W'(count_ff);
            drnd = 1'b0;
         end
         DSEL_CY0: begin
            dnum = NUM_W'(sum_y_ff);
            dden = DEN_W'(count_ff);
            drnd = 1'b0;
         end
         DSEL_CX: begin
            dnum = NUM_W'(wx_ff);
            dden = den_ff;
            drnd = 1'b1;
         end
         default: begin
            dnum = NUM_W'(wy_ff);
            dden = den_ff;
            drnd = 1'b1;
         end
      endcase
   end

   pcp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .rnd   (drnd),
      .num   (dnum),
      .den   (dden),
      .busy  (dbusy),
      .quo   (dquo)
   );

   always_comb begin
      if (dquo > (NUM_W+1)'(32767)) begin
         dsat = 16'sh7FFF;
      end else if (dquo < -(NUM_W+1)'(32768)) begin
         dsat = -16'sh8000;
      end else begin
         dsat = dquo[15:0];
      end
   end

   // square root and CORDIC step logic
   always_comb begin
      sbit     = 36'd1 << (2 * (SQRT_STEPS - 1 - int'(pcnt_ff)));
      s_try    = sr_ff + sbit;
      sroot    = sr_ff + ((sv_ff > sr_ff) ? 36'd1 : 36'd0);
      pol_dist = (sroot > 36'd131071) ? 17'h1FFFF : sroot[16:0];
      xs       = cxr_ff >>> pcnt_ff;
      ys       = cyr_ff >>> pcnt_ff;
      ang      = zero_ff ? 16'd0 : 16'((z_ff + 32'h8000) >> 16);
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.store_wr && (count_ff < CNT_W'(MAX_VERTICES))) begin
         vert_mem_ff[count_ff[ADDR_W-1:0]] <= {in_x, in_y};
      end
      vrd_ff <= vert_mem_ff[cmd.rd_addr];
      if (cmd.pol_store) begin
         res_mem_ff[cmd.idx] <= {pol_dist, ang};
      end
      rrd_ff <= res_mem_ff[cmd.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.clear_poly) begin
         count_ff <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.store_wr) begin
         if (count_ff < CNT_W'(MAX_VERTICES)) begin
            count_ff <= count_ff + 1'b1;
            sum_x_ff <= sum_x_ff + 21'(in_x);
            sum_y_ff <= sum_y_ff + 21'(in_y);
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_take) begin
         case (cmd.div_sel)
            DSEL_CX0: cx0_ff <= dsat;
            DSEL_CY0: cy0_ff <= dsat;
            DSEL_CX:  cx_ff  <= dsat;
            default:  cy_ff  <= dsat;
         endcase
      end
      if (cmd.cap_i) begin
         xi_ff <= rd_x;
         yi_ff <= rd_y;
      end
      if (cmd.area_mul) begin
         p1_ff  <= e1x * e2y;
         p2_ff  <= e1y * e2x;
         wsx_ff <= 18'(cx0_ff) + 18'(xi_ff) + 18'(rd_x);
         wsy_ff <= 18'(cy0_ff) + 18'(yi_ff) + 18'(rd_y);
      end
      if (cmd.area_sub) begin
         a2_ff <= 35'(p1_ff) - 35'(p2_ff);
      end
      if (cmd.acc_clear) begin
         a2sum_ff <= '0;
         wx_ff    <= '0;
         wy_ff    <= '0;
         rmax_ff  <= '0;
      end else begin
         if (cmd.area_wmul) begin
            pwx_ff   <= a2_ff * wsx_ff;
            pwy_ff   <= a2_ff * wsy_ff;
            a2sum_ff <= a2sum_ff + 41'(a2_ff);
         end
         if (cmd.area_acc) begin
            wx_ff <= wx_ff + 59'(pwx_ff);
            wy_ff <= wy_ff + 59'(pwy_ff);
         end
         if (cmd.pol_store && (pol_dist > rmax_ff)) begin
            rmax_ff <= pol_dist;
         end
      end
      if (cmd.den_load) begin
         den_ff <= DEN_W'({a2sum_ff, 1'b0}) + DEN_W'(a2sum_ff);
      end
      if (cmd.pol_diff) begin
         dx_ff <= 17'(rd_x) - 17'(cx_ff);
         dy_ff <= 17'(rd_y) - 17'(cy_ff);
      end
      if (cmd.pol_sq) begin
         dxx_ff <= 34'(dx_ff) * 34'(dx_ff);
         dyy_ff <= 34'(dy_ff) * 34'(dy_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pbusy_ff <= 1'b0;
      end else if (cmd.pol_start) begin
         pbusy_ff <= 1'b1;
      end else if (pbusy_ff && (pcnt_ff == POL_CNT_W'(POL_STEPS - 1))) begin
         pbusy_ff <= 1'b0;
      end
      if (cmd.pol_start) begin
         pcnt_ff <= '0;
         sv_ff   <= 36'(dxx_ff) + 36'(dyy_ff);
         sr_ff   <= '0;
         zero_ff <= (dx_ff == '0) && (dy_ff == '0);
         if (dx_ff < 0) begin
            if (dy_ff >= 0) begin
               cxr_ff <= CRD_W'(dy_ff) <<< 8;
               cyr_ff <= -(CRD_W'(dx_ff) <<< 8);
               z_ff   <= 32'h40000000;
            end else begin
               cxr_ff <= -(CRD_W'(dy_ff) <<< 8);
               cyr_ff <= CRD_W'(dx_ff) <<< 8;
               z_ff   <= 32'hC0000000;
            end
         end else begin
            cxr_ff <= CRD_W'(dx_ff) <<< 8;
            cyr_ff <= CRD_W'(dy_ff) <<< 8;
            z_ff   <= '0;
         end
      end else if (pbusy_ff) begin
         pcnt_ff <= pcnt_ff + 1'b1;
         if (int'(pcnt_ff) < SQRT_STEPS) begin
            if (sv_ff >= s_try) begin
               sv_ff <= sv_ff - s_try;
               sr_ff <= (sr_ff >> 1) + sbit;
            end else begin
               sr_ff <= sr_ff >> 1;
            end
         end
         if (int'(pcnt_ff) < CORDIC_STEPS) begin
            if (cyr_ff > 0) begin
               cxr_ff <= cxr_ff + ys;
               cyr_ff <= cyr_ff - xs;
               z_ff   <= z_ff + atan_val(5'(pcnt_ff));
            end else begin
               cxr_ff <= cxr_ff - ys;
               cyr_ff <= cyr_ff + xs;
               z_ff   <= z_ff - atan_val(5'(pcnt_ff));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         o_st_ff   <= cmd.out_status;
         o_last_ff <= cmd.out_last;
         if (cmd.out_status == ST_OK) begin
            o_idx_ff  <= 5'(cmd.idx);
            o_dist_ff <= rrd_ff[32:16];
            o_ang_ff  <= rrd_ff[15:0];
            o_cx_ff   <= cx_ff;
            o_cy_ff   <= cy_ff;
            o_rmax_ff <= rmax_ff;
         end else begin
            o_idx_ff  <= '0;
            o_dist_ff <= '0;
            o_ang_ff  <= '0;
            o_cx_ff   <= '0;
            o_cy_ff   <= '0;
            o_rmax_ff <= '0;
         end
      end
   end

   assign stat.div_busy = dbusy;
   assign stat.pol_busy = pbusy_ff;
   assign stat.out_free = out_free;
   assign stat.overflow = ovf_ff;
   assign stat.area_bad = (a2sum_ff <= 0);
   assign stat.count    = count_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_vertex_index   = o_idx_ff;
   assign rsp_polar_distance = o_dist_ff;
   assign rsp_polar_angle    = o_ang_ff;
   assign rsp_centroid_x     = o_cx_ff;
   assign rsp_centroid_y     = o_cy_ff;
   assign rsp_bound_radius   = o_rmax_ff;
   assign rsp_status         = o_st_ff;
   assign rsp_last_result    = o_last_ff;

endmodule

`default_nettype wire

FILE: design/pcp_ctrl.sv
// ----------------------------------------------------------------------------
// pcp_ctrl
// Sequencer: load, fan centre, area pass, centroid, polar pass, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module pcp_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_last,
   output logic                  req_ready,
   input  wire pcp_pkg::stat_type stat,
   output pcp_pkg::cmd_type      cmd
);
   import pcp_pkg::*;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              idx_last;
   logic [ADDR_W-1:0] jidx;

   assign idx_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == stat.count);
   assign jidx     = idx_last ? '0 : idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      cmd         = '0;
      cmd.rd_addr = idx_ff;
      cmd.idx     = idx_ff;
      req_ready   = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.store_wr = 1'b1;
               if (req_last) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (stat.overflow || (stat.count < CNT_W'(3))) begin
               if (stat.out_free) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_status = stat.overflow ? ST_OVF : ST_FEW;
                  cmd.out_last   = 1'b1;
                  cmd.clear_poly = 1'b1;
                  state_in       = S_LOAD;
               end
            end else begin
               cmd.acc_clear = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = DSEL_CX0;
               state_in      = S_WX0;
            end
         end
         S_WX0: begin
            cmd.div_sel = DSEL_CX0;
            if (!stat.div_busy) begin
               cmd.div_take = 1'b1;
               state_in     = S_DY0;
            end
         end
         S_DY0: begin
            cmd.div_sel   = DSEL_CY0;
            cmd.div_start = 1'b1;
            state_in      = S_WY0;
         end
         S_WY0: begin
            cmd.div_sel = DSEL_CY0;
            if (!stat.div_busy) begin
               cmd.div_take = 1'b1;
               idx_in       = '0;
               state_in     = S_ARDI;
            end
         end
         S_ARDI: begin
            state_in = S_ARDJ;
         end
         S_ARDJ: begin
            cmd.rd_addr = jidx;
            cmd.cap_i   = 1'b1;
            state_in    = S_AMUL;
         end
         S_AMUL: begin
            cmd.area_mul = 1'b1;
            state_in     = S_ASUB;
         end
         S_ASUB: begin
            cmd.area_sub = 1'b1;
            state_in     = S_AWMUL;
         end
         S_AWMUL: begin
            cmd.area_wmul = 1'b1;
            state_in      = S_AACC;
         end
         S_AACC: begin
            cmd.area_acc = 1'b1;
            if (idx_last) begin
               state_in = S_ACHK;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_ARDI;
            end
         end
         S_ACHK: begin
            if (stat.area_bad) begin
               if (stat.out_free) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_status = ST_AREA;
                  cmd.out_last   = 1'b1;
                  cmd.clear_poly = 1'b1;
                  state_in       = S_LOAD;
               end
            end else begin
               cmd.den_load = 1'b1;
               state_in     = S_DX;
            end
         end
         S_DX: begin
            cmd.div_sel   = DSEL_CX;
            cmd.div_start = 1'b1;
            state_in      = S_WX;
         end
         S_WX: begin
            cmd.div_sel = DSEL_CX;
            if (!stat.div_busy) begin
               cmd.div_take = 1'b1;
               state_in     = S_DY;
            end
         end
         S_DY: begin
            cmd.div_sel   = DSEL_CY;
            cmd.div_start = 1'b1;
            state_in      = S_WY;
         end
         S_WY: begin
            cmd.div_sel = DSEL_CY;
            if (!stat.div_busy) begin
               cmd.div_take = 1'b1;
               idx_in       = '0;
               state_in     = S_PRD;
            end
         end
         S_PRD: begin
            state_in = S_PDIFF;
         end
         S_PDIFF: begin
            cmd.pol_diff = 1'b1;
            state_in     = S_PSQ;
         end
         S_PSQ: begin
            cmd.pol_sq = 1'b1;
            state_in   = S_PSTART;
         end
         S_PSTART: begin
            cmd.pol_start = 1'b1;
            state_in      = S_PRUN;
         end
         S_PRUN: begin
            if (!stat.pol_busy) begin
               cmd.pol_store = 1'b1;
               if (idx_last) begin
                  idx_in   = '0;
                  state_in = S_ERD;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_PRD;
               end
            end
         end
         S_ERD: begin
            state_in = S_EOUT;
         end
         S_EOUT: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = ST_OK;
               cmd.out_last   = idx_last;
               if (idx_last) begin
                  cmd.clear_poly = 1'b1;
                  idx_in         = '0;
                  state_in       = S_LOAD;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_ERD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/polygon_centroid_polar.sv
// ----------------------------------------------------------------------------
// polygon_centroid_polar
// Area centroid of a polygon and polar form of each vertex about it.
// ----------------------------------------------------------------------------
// Vertices load at one item per cycle; the item with last_vertex set starts
// the computation and no new vertex is taken until its last result is in
// the output register. A polygon then runs four divisions in the shared
// serial divider (fan centre x/y, centroid x/y), an area pass and a polar
// pass over its vertices (18-step square root running beside the 16-step
// CORDIC) and emits one result per vertex. Status results come after the
// last vertex (or after the area pass for a non-positive area).
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_centroid_polar (
   input  wire logic   clock,
   input  wire logic   reset,
   pcp_req_if.sink     req_if,
   pcp_rsp_if.source   rsp_if
);
   import pcp_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last_vertex),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pcp_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .in_x               (req_if.vertex_x),
      .in_y               (req_if.vertex_y),
      .rsp_ready          (rsp_if.ready),
      .rsp_valid          (rsp_if.valid),
      .rsp_vertex_index   (rsp_if.vertex_index),
      .rsp_polar_distance (rsp_if.polar_distance),
      .rsp_polar_angle    (rsp_if.polar_angle),
      .rsp_centroid_x     (rsp_if.centroid_x),
      .rsp_centroid_y     (rsp_if.centroid_y),
      .rsp_bound_radius   (rsp_if.bound_radius),
      .rsp_status         (rsp_if.status),
      .rsp_last_result    (rsp_if.last_result)
   );

endmodule

`default_nettype wire

FILE: dv/pcp_tb_if.sv
// ----------------------------------------------------------------------------
// pcp testbench channels
// Item types that the testbench moves on the valid/ready channels of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
// The channel interfaces pcp_req_if and pcp_rsp_if come from design/pcp_if.sv.
// This file only holds the item types that the testbench moves on them.
package pcp_tb_pkg;
   typedef struct {
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic               lastv;
   } vertex_item_t;

   typedef struct packed {
      logic [4:0]         index;
      logic [16:0]        distance;
      logic signed [15:0] angle;
      logic signed [15:0] cen_x;
      logic signed [15:0] cen_y;
      logic [16:0]        radius;
      logic [1:0]         status;
      logic               lastr;
   } polar_item_t;
endpackage

FILE: dv/tb_polygon_centroid_polar.sv
// ----------------------------------------------------------------------------
// tb_polygon_centroid_polar
// Polygons are loaded vertex by vertex. The testbench predicts the centroid,
// distance, angle and status of every result and checks each one, with
// random idle and stall phases on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_polygon_centroid_polar;
   import pcp_pkg::*;
   import pcp_tb_pkg::*;

   localparam logic [31:0] ATAN_TAB [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

   logic clock;
   logic reset;
   pcp_req_if req_ch();
   pcp_rsp_if rsp_ch();

   polygon_centroid_polar dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch.sink),
      .rsp_if(rsp_ch.source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // polygon state kept by the predictor
   longint      poly_x [32];
   longint      poly_y [32];
   int          poly_count;
   longint      poly_sum_x;
   longint      poly_sum_y;
   bit          poly_ovf;
   polar_item_t expected_q[$];
   int          mismatches;
   int          results_seen;
   int          polygons_sent;
   int          idle_pct;
   int          stall_pct;

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint div_nearest(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint sqrt_nearest(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      if (v > r) r++;
      return r;
   endfunction

   function automatic logic [15:0] vector_angle(longint dx, longint dy);
      longint x, y, t, xs, ys;
      logic [31:0] z;
      x = dx * 256;
      y = dy * 256;
      z = 0;
      if (dx == 0 && dy == 0) return 16'd0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 32'h40000000;
         end else begin
            t = x; x = -y; y = t; z = 32'hC0000000;
         end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = shr_floor(x, i);
         ys = shr_floor(y, i);
         if (y > 0) begin
            x += ys; y -= xs; z += ATAN_TAB[i];
         end else begin
            x -= ys; y += xs; z -= ATAN_TAB[i];
         end
      end
      z = z + 32'h8000;
      return z[31:16];
   endfunction

   function automatic void clear_poly();
      poly_count = 0;
      poly_sum_x = 0;
      poly_sum_y = 0;
      poly_ovf   = 0;
   endfunction

   function automatic void push_status(logic [1:0] st);
      polar_item_t r;
      r = '{index: 0, distance: 0, angle: 0, cen_x: 0, cen_y: 0, radius: 0,
            status: st, lastr: 1'b1};
      expected_q.push_back(r);
   endfunction

   function automatic void predict_vertex(vertex_item_t v);
      longint c0x, c0y, a2, a2sum, wx, wy, e1x, e1y, e2x, e2y, cx, cy, dx, dy, d, rmax;
      longint dists [32];
      logic [15:0] ang [32];
      int j, n;
      polar_item_t r;
      if (poly_count < MAX_VERTICES) begin
         poly_x[poly_count] = v.vx;
         poly_y[poly_count] = v.vy;
         poly_sum_x += v.vx;
         poly_sum_y += v.vy;
         poly_count++;
      end else poly_ovf = 1;
      if (!v.lastv) return;
      n = poly_count;
      if (poly_ovf) begin
         push_status(ST_OVF); clear_poly(); return;
      end
      if (n < 3) begin
         push_status(ST_FEW); clear_poly(); return;
      end
      c0x = poly_sum_x / n;
      c0y = poly_sum_y / n;
      a2sum = 0; wx = 0; wy = 0;
      for (int i = 0; i < n; i++) begin
         j = (i + 1 < n) ? i + 1 : 0;
         e1x = poly_x[j] - poly_x[i];
         e1y = poly_y[j] - poly_y[i];
         e2x = c0x - poly_x[i];
         e2y = c0y - poly_y[i];
         a2 = e1x * e2y - e1y * e2x;
         a2sum += a2;
         wx += a2 * (c0x + poly_x[i] + poly_x[j]);
         wy += a2 * (c0y + poly_y[i] + poly_y[j]);
      end
      if (a2sum <= 0) begin
         push_status(ST_AREA); clear_poly(); return;
      end
      cx = clamp16(div_nearest(wx, 3 * a2sum));
      cy = clamp16(div_nearest(wy, 3 * a2sum));
      rmax = 0;
      for (int i = 0; i < n; i++) begin
         dx = poly_x[i] - cx;
         dy = poly_y[i] - cy;
         d = sqrt_nearest(dx * dx + dy * dy);
         if (d > 131071) d = 131071;
         dists[i] = d;
         ang[i] = vector_angle(dx, dy);
         if (d > rmax) rmax = d;
      end
      for (int i = 0; i < n; i++) begin
         r.index    = i[4:0];
         r.distance = dists[i][16:0];
         r.angle    = ang[i];
         r.cen_x    = cx[15:0];
         r.cen_y    = cy[15:0];
         r.radius   = rmax[16:0];
         r.status   = ST_OK;
         r.lastr    = (i + 1 == n);
         expected_q.push_back(r);
      end
      clear_poly();
   endfunction

   task automatic send_vertex(vertex_item_t v);
      do begin
         req_ch.valid <= ($urandom_range(99) >= idle_pct);
         req_ch.vertex_x    <= v.vx;
         req_ch.vertex_y    <= v.vy;
         req_ch.last_vertex <= v.lastv;
         @(posedge clock);
         while (!(req_ch.valid && req_ch.ready)) begin
            @(negedge clock);
            if (!req_ch.valid) req_ch.valid <= ($urandom_range(99) >= idle_pct);
            @(posedge clock);
         end
         predict_vertex(v);
         @(negedge clock);
      end while (0);
   endtask

   task automatic send_polygon(vertex_item_t verts[$]);
      foreach (verts[i]) send_vertex(verts[i]);
      polygons_sent++;
   endtask

   // random convex-ish polygon around a center, counterclockwise, or clockwise when reverse is set
   task automatic send_random_polygon(int n, int radius, bit reverse);
      vertex_item_t verts[$];
      vertex_item_t v;
      real a, rr;
      int ox, oy, k;
      ox = $urandom_range(2 * (32767 - radius)) - (32767 - radius);
      oy = $urandom_range(2 * (32767 - radius)) - (32767 - radius);
      for (int i = 0; i < n; i++) begin
         k = reverse ? n - 1 - i : i;
         a  = 6.2831853 * (k + 0.3 * ($urandom_range(100) / 100.0)) / n;
         rr = radius * (0.6 + 0.4 * ($urandom_range(100) / 100.0));
         v.vx = 16'(ox + int'(rr * $cos(a)));
         v.vy = 16'(oy + int'(rr * $sin(a)));
         v.lastv = (i == n - 1);
         verts.push_back(v);
      end
      send_polygon(verts);
   endtask

   task automatic send_noise_polygon(int n);
      vertex_item_t verts[$];
      vertex_item_t v;
      for (int i = 0; i < n; i++) begin
         v.vx = 16'($urandom);
         v.vy = 16'($urandom);
         v.lastv = (i == n - 1);
         verts.push_back(v);
      end
      send_polygon(verts);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      polar_item_t e, a;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         a = '{index: rsp_ch.vertex_index, distance: rsp_ch.polar_distance,
               angle: rsp_ch.polar_angle, cen_x: rsp_ch.centroid_x,
               cen_y: rsp_ch.centroid_y, radius: rsp_ch.bound_radius,
               status: rsp_ch.status, lastr: rsp_ch.last_result};
         results_seen++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result idx %0d status %0d",
                                           a.index, a.status);
         end else begin
            e = expected_q.pop_front();
            if (a !== e) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch exp idx %0d d %0d ang %0d c %0d,%0d r %0d st %0d l %0d",
                           e.index, e.distance, e.angle, e.cen_x, e.cen_y, e.radius,
                           e.status, e.lastr);
                  $display("         got idx %0d d %0d ang %0d c %0d,%0d r %0d st %0d l %0d",
                           a.index, a.distance, a.angle, a.cen_x, a.cen_y, a.radius,
                           a.status, a.lastr);
               end
            end
         end
      end
   end

   // directed table: x, y, last, expected status where obvious (-1 = predicted)
   typedef struct {
      int x;
      int y;
      bit l;
      int st;
   } dir_row_t;

   localparam int DIR_N = 23;
   dir_row_t dir_tab [DIR_N] = '{
      '{0, 0, 1, ST_FEW},
      '{100, 0, 0, -1}, '{-100, 0, 1, ST_FEW},
      '{0, 0, 0, -1}, '{256, 0, 0, -1}, '{0, 256, 1, -1},
      '{0, 0, 0, -1}, '{0, 256, 0, -1}, '{256, 0, 1, ST_AREA},
      '{0, 0, 0, -1}, '{100, 100, 0, -1}, '{200, 200, 1, ST_AREA},
      '{-32768, -32768, 0, -1}, '{32767, -32768, 0, -1},
      '{32767, 32767, 0, -1}, '{-32768, 32767, 1, -1},
      '{-32768, 0, 0, -1}, '{32767, 0, 0, -1}, '{0, 32767, 0, -1},
      '{0, 0, 1, -1},
      '{-1, -1, 0, -1}, '{1, -1, 0, -1}, '{0, 1, 1, -1}};

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      vertex_item_t v;
      vertex_item_t verts[$];
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.vertex_x = '0;
      req_ch.vertex_y = '0;
      req_ch.last_vertex = 1'b0;
      rsp_ch.ready = 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      mismatches = 0;
      results_seen = 0;
      polygons_sent = 0;
      clear_poly();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_tab[i]) begin
         v.vx = 16'(dir_tab[i].x);
         v.vy = 16'(dir_tab[i].y);
         v.lastv = dir_tab[i].l;
         send_vertex(v);
         if (dir_tab[i].st >= 0 && (expected_q.size() != 1 ||
             expected_q[0].status != dir_tab[i].st)) begin
            mismatches++;
            if (mismatches <= 10)
               $display("directed row %0d: status %0d not predicted", i, dir_tab[i].st);
         end
      end
      // overflow: 34 vertices then a fresh polygon
      verts.delete();
      for (int i = 0; i < 34; i++) begin
         v.vx = 16'(i * 7); v.vy = 16'(i * i); v.lastv = (i == 33);
         verts.push_back(v);
      end
      send_polygon(verts);
      if (expected_q[$].status != ST_OVF) begin
         mismatches++;
         if (mismatches <= 10) $display("overflow polygon not predicted as overflow");
      end
      // full 32-vertex polygon
      send_random_polygon(32, 20000, 0);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 12 : 83) : 0;
         stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 12 : 83) : 0;
         for (int p = 0; p < 2; p++) begin
            case ($urandom_range(9))
               0: send_noise_polygon($urandom_range(1, 4));
               1: send_random_polygon($urandom_range(3, 4), $urandom_range(1, 30), 1);
               default: send_random_polygon($urandom_range(3, 5),
                                            $urandom_range(2, 16000), 0);
            endcase
         end
         drain();
      end

      repeat (400) @(posedge clock);
      $display("Ran %0d polygons with %0d checked results over four idle/stall phases.",
               polygons_sent, results_seen);
      if (mismatches == 0 && expected_q.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: sim.f
design/pcp_pkg.sv
design/pcp_if.sv
design/pcp_div.sv
design/pcp_dp.sv
design/pcp_ctrl.sv
design/polygon_centroid_polar.sv
dv/pcp_tb_if.sv
dv/tb_polygon_centroid_polar.sv
